>>> rtl/tscf_pkg.sv
// ----------------------------------------------------------------------------
// tscf_pkg: shared types and constants
// Word formats, request codes and fixed limits of the capture recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package tscf_pkg;

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_DRAIN  = 2'd2;
    localparam logic [1:0] REQ_STOP   = 2'd3;

    localparam logic [16:0] DUR_RESET  = 17'd30000;
    localparam logic [16:0] DUR_MIN    = 17'd5000;
    localparam logic [16:0] DUR_MAX    = 17'd100000;
    localparam int          CAP_MIN_MS = 1000;

    localparam logic [15:0] RPM_POS_MAX = 16'h7FFF;   // 32767
    localparam logic [15:0] RPM_NEG_MIN = 16'h8000;   // -32768
    localparam logic [31:0] I32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_MIN     = 32'h8000_0000;
    localparam logic [15:0] IDX_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        time_ms;
        logic signed [23:0] rpm_q4;
        logic signed [63:0] encoder_counts;
        logic [31:0]        index_count;
    } t_in_word;

    typedef struct packed {
        logic               record_valid;
        logic [15:0]        record_slot;
        logic [31:0]        rel_time_ms;
        logic signed [15:0] rpm_x10;
        logic signed [31:0] rel_counts;
        logic [15:0]        rel_index;
        logic               running;
        logic               done_pulse;
        logic [16:0]        stored_count;
        logic [31:0]        hit_count;
        logic [31:0]        drop_count;
    } t_out_word;

    // one ring entry, 96 bits
    typedef struct packed {
        logic [31:0] t;
        logic [15:0] rpm10;
        logic [31:0] cnt;
        logic [15:0] idx;
    } t_entry;

    // control result of stage 1, handed to the record stage
    typedef struct packed {
        logic        is_start;
        logic        pop;
        logic        rec_valid;
        logic [15:0] slot;
        logic        running;
        logic        done;
        logic [16:0] stored;
        logic [31:0] hit;
        logic [31:0] drop;
    } t_stage1;

endpackage

`default_nettype wire

>>> rtl/tscf_ring_mem.sv
// ----------------------------------------------------------------------------
// tscf_ring_mem: ring entry storage
// One write port, one registered read port; contents undefined after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_ring_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire                   i_clk,
    input  wire                   i_wr_en,
    input  wire [AW-1:0]          i_wr_addr,
    input  wire tscf_pkg::t_entry i_wr_data,
    input  wire                   i_rd_en,
    input  wire [AW-1:0]          i_rd_addr,
    output tscf_pkg::t_entry      o_rd_data
);

    tscf_pkg::t_entry r_mem [DEPTH];
    tscf_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/tscf_ctrl.sv
// ----------------------------------------------------------------------------
// tscf_ctrl: request decode and ring control
// Run flag, pointers, timers and counters; issues ring writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_ctrl #(
    parameter int          RING_DEPTH = 512,
    parameter int          AW         = 9,
    parameter int          SW         = 17,
    parameter int          CAPACITY   = 65536,
    parameter logic [16:0] CAP_MS     = 17'd32768
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire [16:0]              i_cfg_wr_data,
    input  wire                     i_in_valid,
    input  wire tscf_pkg::t_in_word i_in_word,
    output logic                    o_in_ready,
    input  wire                     i_s1_take,
    output logic                    o_s1_valid,
    output tscf_pkg::t_stage1       o_s1,
    output logic [31:0]             o_start_time,
    output logic                    o_mem_wr_en,
    output logic [AW-1:0]           o_mem_wr_addr,
    output tscf_pkg::t_entry        o_mem_wr_data,
    output logic                    o_mem_rd_en,
    output logic [AW-1:0]           o_mem_rd_addr
);

    logic [16:0]       r_dur;
    logic              r_run,   n_run;
    logic [AW-1:0]     r_wp,    n_wp;
    logic [AW-1:0]     r_rp,    n_rp;
    logic [31:0]       r_start, n_start;
    logic [31:0]       r_end,   n_end;
    logic [SW-1:0]     r_stored, n_stored;
    logic [31:0]       r_hit,   n_hit;
    logic [31:0]       r_drop,  n_drop;
    logic              r_s1_valid;
    tscf_pkg::t_stage1 r_s1,    n_s1;

    logic              accept;
    logic              done;
    logic              pop;
    logic              rec_valid;
    logic              wr_en;
    logic [AW-1:0]     wp_next;
    logic [AW-1:0]     rp_next;
    logic [16:0]       dur_clamp;
    logic              past_end;

    // speed conversion
    logic              rpm_neg;
    logic [23:0]       rpm_mag;
    logic [27:0]       rpm_prod;
    logic [23:0]       rpm_r;
    logic [15:0]       rpm10;
    logic              cnt_fits;
    logic [31:0]       cnt_sat;
    logic [15:0]       idx_sat;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, p} + 1'b1;
        ring_next = (s >= (AW+1)'(RING_DEPTH)) ? '0 : s[AW-1:0];
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid || i_s1_take;
    assign wp_next    = ring_next(r_wp);
    assign rp_next    = ring_next(r_rp);
    assign past_end   = i_in_word.time_ms >= r_end;

    always_comb begin
        if (r_dur < tscf_pkg::DUR_MIN) begin
            dur_clamp = tscf_pkg::DUR_MIN;
        end else if (r_dur > tscf_pkg::DUR_MAX) begin
            dur_clamp = tscf_pkg::DUR_MAX;
        end else begin
            dur_clamp = r_dur;
        end
        if (dur_clamp > CAP_MS) begin
            dur_clamp = CAP_MS;
        end
    end

    // rpm*10/16 rounded half away from zero, saturated to int16
    always_comb begin
        rpm_neg  = i_in_word.rpm_q4[23];
        rpm_mag  = rpm_neg ? (~i_in_word.rpm_q4 + 24'd1) : i_in_word.rpm_q4;
        rpm_prod = {1'b0, rpm_mag, 3'b000} + {3'b000, rpm_mag, 1'b0} + 28'd8;
        rpm_r    = rpm_prod[27:4];
        if (!rpm_neg) begin
            rpm10 = (rpm_r > 24'd32767) ? tscf_pkg::RPM_POS_MAX : rpm_r[15:0];
        end else begin
            rpm10 = (rpm_r > 24'd32768) ? tscf_pkg::RPM_NEG_MIN
                                        : (~rpm_r[15:0] + 16'd1);
        end
    end

    assign cnt_fits = (&i_in_word.encoder_counts[63:31])
                   || (~|i_in_word.encoder_counts[63:31]);
    assign cnt_sat  = cnt_fits ? i_in_word.encoder_counts[31:0]
                    : (i_in_word.encoder_counts[63] ? tscf_pkg::I32_MIN
                                                    : tscf_pkg::I32_MAX);
    assign idx_sat  = (|i_in_word.index_count[31:16]) ? tscf_pkg::IDX_MAX
                                                      : i_in_word.index_count[15:0];

    always_comb begin
        n_run     = r_run;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_start   = r_start;
        n_end     = r_end;
        n_stored  = r_stored;
        n_hit     = r_hit;
        n_drop    = r_drop;
        done      = 1'b0;
        pop       = 1'b0;
        rec_valid = 1'b0;
        wr_en     = 1'b0;
        case (i_in_word.req_type)
            tscf_pkg::REQ_START: begin
                n_wp     = '0;
                n_rp     = '0;
                n_start  = i_in_word.time_ms;
                n_end    = i_in_word.time_ms + {15'd0, dur_clamp};
                n_stored = '0;
                n_hit    = '0;
                n_drop   = '0;
                n_run    = 1'b1;
            end
            tscf_pkg::REQ_SAMPLE: begin
                if (r_run) begin
                    n_hit = r_hit + 32'd1;
                    if (past_end) begin
                        n_run = 1'b0;
                        done  = 1'b1;
                    end else if (wp_next == r_rp) begin
                        n_drop = r_drop + 32'd1;
                    end else begin
                        wr_en = 1'b1;
                        n_wp  = wp_next;
                    end
                end
            end
            tscf_pkg::REQ_DRAIN: begin
                if (r_rp != r_wp) begin
                    pop  = 1'b1;
                    n_rp = rp_next;
                    if (r_stored >= SW'(CAPACITY)) begin
                        done  = r_run;
                        n_run = 1'b0;
                    end else begin
                        rec_valid = 1'b1;
                        n_stored  = r_stored + 1'b1;
                    end
                end
                // empty ring past the end time closes the run
                if (n_run && past_end && (n_rp == r_wp)) begin
                    n_run = 1'b0;
                    done  = 1'b1;
                end
            end
            default: begin
                done  = r_run;
                n_run = 1'b0;
            end
        endcase

        n_s1.is_start  = (i_in_word.req_type == tscf_pkg::REQ_START);
        n_s1.pop       = pop;
        n_s1.rec_valid = rec_valid;
        n_s1.slot      = 16'(r_stored);
        n_s1.running   = n_run;
        n_s1.done      = done;
        n_s1.stored    = 17'(n_stored);
        n_s1.hit       = n_hit;
        n_s1.drop      = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur      <= tscf_pkg::DUR_RESET;
            r_run      <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_start    <= '0;
            r_end      <= '0;
            r_stored   <= '0;
            r_hit      <= '0;
            r_drop     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dur <= i_cfg_wr_data;
            end
            if (accept) begin
                r_run    <= n_run;
                r_wp     <= n_wp;
                r_rp     <= n_rp;
                r_start  <= n_start;
                r_end    <= n_end;
                r_stored <= n_stored;
                r_hit    <= n_hit;
                r_drop   <= n_drop;
            end
            if (o_in_ready) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid          = r_s1_valid;
    assign o_s1                = r_s1;
    assign o_start_time        = r_start;
    assign o_mem_wr_en         = accept && wr_en;
    assign o_mem_wr_addr       = r_wp;
    assign o_mem_wr_data.t     = i_in_word.time_ms;
    assign o_mem_wr_data.rpm10 = rpm10;
    assign o_mem_wr_data.cnt   = cnt_sat;
    assign o_mem_wr_data.idx   = idx_sat;
    assign o_mem_rd_en         = accept && pop;
    assign o_mem_rd_addr       = r_rp;

endmodule

`default_nettype wire

>>> rtl/tscf_rec.sv
// ----------------------------------------------------------------------------
// tscf_rec: record stage and output register
// Sets bases from the first popped entry and forms the relative record.
// ----------------------------------------------------------------------------
`default_nettype none

module tscf_rec (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s1_valid,
    input  wire tscf_pkg::t_stage1  i_s1,
    input  wire tscf_pkg::t_entry   i_entry,
    input  wire [31:0]              i_start_time,
    output logic                    o_s1_take,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output tscf_pkg::t_out_word     o_out_word
);

    logic                r_base_known, n_base_known;
    logic [31:0]         r_cnt_base,   n_cnt_base;
    logic [15:0]         r_idx_base,   n_idx_base;
    logic                r_out_valid;
    tscf_pkg::t_out_word r_out,        n_out;

    assign o_s1_take = i_s1_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_base_known = r_base_known;
        n_cnt_base   = r_cnt_base;
        n_idx_base   = r_idx_base;
        if (i_s1.is_start) begin
            n_base_known = 1'b0;
            n_cnt_base   = '0;
            n_idx_base   = '0;
        end else if (i_s1.pop && !r_base_known) begin
            n_base_known = 1'b1;
            n_cnt_base   = i_entry.cnt;
            n_idx_base   = i_entry.idx;
        end

        n_out              = '0;
        n_out.running      = i_s1.running;
        n_out.done_pulse   = i_s1.done;
        n_out.stored_count = i_s1.stored;
        n_out.hit_count    = i_s1.hit;
        n_out.drop_count   = i_s1.drop;
        if (i_s1.rec_valid) begin
            n_out.record_valid = 1'b1;
            n_out.record_slot  = i_s1.slot;
            n_out.rel_time_ms  = (i_entry.t >= i_start_time) ? (i_entry.t - i_start_time)
                                                             : 32'd0;
            n_out.rpm_x10      = i_entry.rpm10;
            n_out.rel_counts   = i_entry.cnt - n_cnt_base;
            n_out.rel_index    = (i_entry.idx >= n_idx_base) ? (i_entry.idx - n_idx_base)
                                                             : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_known <= 1'b0;
            r_cnt_base   <= '0;
            r_idx_base   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_s1_take) begin
                r_base_known <= n_base_known;
                r_cnt_base   <= n_cnt_base;
                r_idx_base   <= n_idx_base;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

>>> rtl/timed_sample_capture_fifo_unit.sv
// ----------------------------------------------------------------------------
// timed_sample_capture_fifo_unit: timed capture recorder with ring FIFO
// Input word registers in stage 1, result word in the stage 2 output register.
// One word per cycle unless output stalls, set by the single ring read port.
// Reset: sync active low clears control; ring contents undefined, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_sample_capture_fifo_unit #(
    parameter int RING_DEPTH     = 512,
    parameter int CAPACITY       = 65536,
    parameter int SAMPLE_RATE_HZ = 2000
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire [16:0]              i_cfg_wr_data,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire tscf_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output tscf_pkg::t_out_word     o_out_word
);

    // Pipeline:
    //   stage 1 (ctrl)  decodes the request, updates pointers/counters/run flag,
    //                   writes a sample into the ring or issues the ring read
    //                   for a drain.
    //   stage 2 (rec)   picks up the registered ring read data, resolves
    //                   the count/index bases and loads the output register.
    // Bases live in stage 2 because they come from ring data; each drain sees
    // the bases left by the drain ahead of it, since stage 2 is in order.
    // Accesses never collide: one word is accepted per edge, and a read
    // issued after a write to the same slot sees the written data.

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SW = $clog2(CAPACITY + 1);

    // capacity time = max(1000, CAPACITY*1000/SAMPLE_RATE_HZ), capped at 100000
    localparam longint CAP_MS_RAW  = (64'(CAPACITY) * 64'd1000) / 64'(SAMPLE_RATE_HZ);
    localparam longint CAP_MS_LOW  = (CAP_MS_RAW < tscf_pkg::CAP_MIN_MS)
                                   ? tscf_pkg::CAP_MIN_MS : CAP_MS_RAW;
    localparam logic [16:0] CAP_MS = (CAP_MS_LOW > 100000) ? tscf_pkg::DUR_MAX
                                                           : 17'(CAP_MS_LOW);

    logic                s1_valid;
    logic                s1_take;
    tscf_pkg::t_stage1   s1;
    logic [31:0]         start_time;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    tscf_pkg::t_entry    mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    tscf_pkg::t_entry    mem_rd_data;

    tscf_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW),
        .SW         (SW),
        .CAPACITY   (CAPACITY),
        .CAP_MS     (CAP_MS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_in_ready    (o_in_ready),
        .i_s1_take     (s1_take),
        .o_s1_valid    (s1_valid),
        .o_s1          (s1),
        .o_start_time  (start_time),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr)
    );

    tscf_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // read data holds while stage 1 stalls: reads fire only on accept
    tscf_rec u_rec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1         (s1),
        .i_entry      (mem_rd_data),
        .i_start_time (start_time),
        .o_s1_take    (s1_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

`default_nettype wire
